// File: src/mfg_pkg.sv
package mfg_pkg;

    localparam int DEF_MAX_SPHERES = 16;

    // Field saturation, 1000.0 in Q16.16
    localparam logic [25:0] FIELD_CAP = 26'd65536000;
    // Unit length in Q1.14
    localparam logic [14:0] GRAD_ONE = 15'd16384;

    localparam int ENTRY_W  = 64;
    localparam int DVD_W    = 48;   // (r*r) << 16
    localparam int DVS_W    = 35;   // sum of three squared distances
    localparam int SQ_W     = 54;   // sum of three squared differences
    localparam int ROOT_W   = 27;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_FIELD = 2'd1;
    localparam logic [1:0] ACT_GRAD  = 2'd2;
    localparam logic [1:0] ACT_UNDEF = 2'd3;   // no operation, all-zero result

    localparam logic CFG_SPHERE_COUNT = 1'b0;
    localparam logic CFG_STEP_SIZE    = 1'b1;

    localparam logic [4:0] RST_SPHERE_COUNT = 5'd0;
    localparam logic [7:0] RST_STEP_SIZE    = 8'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         entry_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        radius;
    } t_mfg_in;

    typedef struct packed {
        logic [25:0]        field_value;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
        logic               grad_degenerate;
    } t_mfg_out;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

// File: src/metaball_field_gradient.sv
// A load goes straight to the finish state; a field query reads, squares and
// divides per active sphere; a gradient query runs six field evaluations, the
// square sum, the root and a division per axis. One transaction at a time; the
// serial divider and the six evaluations per gradient set the pace. o_done is
// high for one cycle; o_result holds until the next start; receiver can't stall.
// Reset (synchronous, active low) clears control, sphere_count=0, step_size=3.
module metaball_field_gradient #(
    parameter int MAX_SPHERES = mfg_pkg::DEF_MAX_SPHERES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  mfg_pkg::t_mfg_in  i_item,
    output logic              busy,
    output logic              o_done,
    output mfg_pkg::t_mfg_out o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);

    localparam int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W = $clog2(MAX_SPHERES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_RD, S_MX, S_MY, S_MZ, S_MR, S_DIV,
        S_FDONE, S_SQ, S_SQRT, S_NDIV, S_NWAIT, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0] r_sphere_count;
    logic [7:0] r_step_size;

    // transaction
    logic [1:0]         r_act;
    logic signed [15:0] r_bx, r_by, r_bz;
    mfg_pkg::t_mfg_out  r_res;
    logic               r_done;

    // field evaluation
    logic [CNT_W-1:0] r_idx;
    logic [2:0]       r_k;      // gradient eval: axis = k>>1, k[0] = minus side
    logic [34:0]      r_d2;
    logic [25:0]      r_sum;
    logic [25:0]      r_fa;

    // gradient
    logic signed [26:0] r_g [3];
    logic [1:0]         r_ax;
    logic [53:0]        r_sq;
    logic [53:0]        r_rad;
    logic [27:0]        r_rem;
    logic [26:0]        r_root;
    logic [4:0]         r_scnt;

    // table
    logic [63:0]       w_rdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;

    // datapath
    logic [CNT_W-1:0]    w_n;
    logic signed [16:0]  w_off, w_px, w_py, w_pz;
    logic signed [17:0]  w_dx, w_dy, w_dz;
    logic signed [26:0]  w_ma;
    logic signed [53:0]  w_prod;
    logic [53:0]         w_sqn;
    logic [26:0]         w_sum_t;
    logic [29:0]         w_rsh, w_trial, w_rdiff;
    logic signed [26:0]  w_gsel;
    logic [26:0]         w_mag;
    logic [14:0]         w_c;
    logic signed [15:0]  w_comp;

    mfg_pkg::t_div_req          w_req;
    logic                       w_div_done;
    logic [mfg_pkg::DVD_W-1:0]  w_quot;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;

    // Table write straight from the accepted load; out-of-range slots dropped.
    assign w_we    = start && !busy && (i_item.action == mfg_pkg::ACT_LOAD)
                     && (int'(i_item.entry_index) < MAX_SPHERES);
    assign w_waddr = AW'(i_item.entry_index);
    assign w_raddr = r_idx[AW-1:0];

    mfg_ram #(
        .WIDTH(mfg_pkg::ENTRY_W),
        .DEPTH(MAX_SPHERES),
        .AW   (AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata({i_item.radius, i_item.pos_z, i_item.pos_y, i_item.pos_x}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    mfg_div #(
        .N(mfg_pkg::DVD_W),
        .D(mfg_pkg::DVS_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_comb begin
        // active count clamps at table depth
        if (int'(r_sphere_count) > MAX_SPHERES) begin
            w_n = CNT_W'(MAX_SPHERES);
        end else begin
            w_n = CNT_W'(r_sphere_count);
        end

        // sample point: base plus/minus step on the current axis
        w_off = '0;
        if (r_act == mfg_pkg::ACT_GRAD) begin
            w_off = r_k[0] ? -$signed({9'd0, r_step_size}) : $signed({9'd0, r_step_size});
        end
        w_px = {r_bx[15], r_bx} + ((r_k[2:1] == 2'd0) ? w_off : 17'sd0);
        w_py = {r_by[15], r_by} + ((r_k[2:1] == 2'd1) ? w_off : 17'sd0);
        w_pz = {r_bz[15], r_bz} + ((r_k[2:1] == 2'd2) ? w_off : 17'sd0);

        w_dx = {w_px[16], w_px} - {{2{w_rdata[15]}}, w_rdata[15:0]};
        w_dy = {w_py[16], w_py} - {{2{w_rdata[31]}}, w_rdata[31:16]};
        w_dz = {w_pz[16], w_pz} - {{2{w_rdata[47]}}, w_rdata[47:32]};

        w_gsel = r_g[r_ax];

        // every product here is a square: one shared multiplier
        case (r_state)
            S_MX:    w_ma = 27'(w_dx);
            S_MY:    w_ma = 27'(w_dy);
            S_MZ:    w_ma = 27'(w_dz);
            S_MR:    w_ma = $signed({11'd0, w_rdata[63:48]});
            S_SQ:    w_ma = w_gsel;
            default: w_ma = '0;
        endcase
        w_prod = w_ma * w_ma;

        w_sqn   = r_sq + 54'(w_prod);
        w_sum_t = {1'b0, r_sum} + {1'b0, w_quot[25:0]};

        // one root bit per cycle
        w_rsh   = {r_rem, r_rad[53:52]};
        w_trial = {1'b0, r_root, 2'b01};
        w_rdiff = w_rsh - w_trial;

        w_mag = w_gsel[26] ? 27'(-w_gsel) : 27'(w_gsel);
        w_c   = (w_quot > mfg_pkg::DVD_W'(mfg_pkg::GRAD_ONE)) ? mfg_pkg::GRAD_ONE
                                                                : w_quot[14:0];
        w_comp = w_gsel[26] ? -$signed({1'b0, w_c}) : $signed({1'b0, w_c});

        w_req.start    = 1'b0;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        if (r_state == S_MR && r_d2 != '0) begin
            w_req.start    = 1'b1;
            w_req.dividend = {w_prod[31:0], 16'd0};
            w_req.divisor  = r_d2;
        end else if (r_state == S_NDIV) begin
            w_req.start    = 1'b1;
            w_req.dividend = mfg_pkg::DVD_W'({w_mag[25:0], 14'd0});
            w_req.divisor  = mfg_pkg::DVS_W'(r_root);
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sphere_count <= mfg_pkg::RST_SPHERE_COUNT;
            r_step_size    <= mfg_pkg::RST_STEP_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfg_pkg::CFG_SPHERE_COUNT: r_sphere_count <= i_cfg_data[4:0];
                mfg_pkg::CFG_STEP_SIZE:    r_step_size    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_act <= i_item.action;
                        r_bx  <= i_item.pos_x;
                        r_by  <= i_item.pos_y;
                        r_bz  <= i_item.pos_z;
                        r_k   <= '0;
                        r_res <= '0;
                        if (i_item.action == mfg_pkg::ACT_FIELD
                            || i_item.action == mfg_pkg::ACT_GRAD) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_EVAL: begin
                    r_sum <= '0;
                    r_idx <= '0;
                    r_state <= (w_n == '0) ? S_FDONE : S_RD;
                end
                S_RD: r_state <= S_MX;
                S_MX: begin
                    r_d2    <= 35'(w_prod);
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_d2    <= r_d2 + 35'(w_prod);
                    r_state <= S_MZ;
                end
                S_MZ: begin
                    r_d2    <= r_d2 + 35'(w_prod);
                    r_state <= S_MR;
                end
                S_MR: begin
                    // point on a centre: field is exactly the cap
                    if (r_d2 == '0) begin
                        r_sum   <= mfg_pkg::FIELD_CAP;
                        r_state <= S_FDONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (w_quot >= mfg_pkg::DVD_W'(mfg_pkg::FIELD_CAP)
                            || w_sum_t >= 27'(mfg_pkg::FIELD_CAP)) begin
                            r_sum <= mfg_pkg::FIELD_CAP;
                        end else begin
                            r_sum <= w_sum_t[25:0];
                        end
                        r_idx <= r_idx + 1'b1;
                        r_state <= (r_idx + 1'b1 == w_n) ? S_FDONE : S_RD;
                    end
                end
                S_FDONE: begin
                    if (r_act == mfg_pkg::ACT_FIELD) begin
                        r_res.field_value <= r_sum;
                        r_state <= S_FIN;
                    end else begin
                        if (!r_k[0]) begin
                            r_fa <= r_sum;
                        end else begin
                            r_g[r_k[2:1]] <= $signed({1'b0, r_fa}) - $signed({1'b0, r_sum});
                        end
                        if (r_k == 3'd5) begin
                            r_ax    <= '0;
                            r_sq    <= '0;
                            r_state <= S_SQ;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_SQ: begin
                    r_sq <= w_sqn;
                    if (r_ax == 2'd2) begin
                        if (w_sqn == '0) begin
                            r_res.grad_degenerate <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_rad   <= w_sqn;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_scnt  <= 5'(mfg_pkg::ROOT_W);
                            r_state <= S_SQRT;
                        end
                    end else begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                S_SQRT: begin
                    r_rad <= {r_rad[51:0], 2'b00};
                    if (!w_rdiff[29]) begin
                        r_rem  <= w_rdiff[27:0];
                        r_root <= {r_root[25:0], 1'b1};
                    end else begin
                        r_rem  <= w_rsh[27:0];
                        r_root <= {r_root[25:0], 1'b0};
                    end
                    r_scnt <= r_scnt - 1'b1;
                    if (r_scnt == 5'd1) begin
                        r_ax    <= '0;
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: r_state <= S_NWAIT;
                S_NWAIT: begin
                    if (w_div_done) begin
                        case (r_ax)
                            2'd0:    r_res.grad_x <= w_comp;
                            2'd1:    r_res.grad_y <= w_comp;
                            default: r_res.grad_z <= w_comp;
                        endcase
                        if (r_ax == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/mfg_ram.sv
module mfg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mfg_div.sv
// Restoring divider, one quotient bit per cycle.
module mfg_div #(
    parameter int N = mfg_pkg::DVD_W,
    parameter int D = mfg_pkg::DVS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mfg_pkg::t_div_req     i_req,
    output logic                  o_done,
    output logic [N-1:0]          o_quot
);

    localparam int CW = $clog2(N + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_dvs;
    logic [N-1:0]  r_q;

    logic [D:0]    w_sh;
    logic [D+1:0]  w_diff;
    logic          w_ge;

    always_comb begin
        w_sh   = {r_rem, r_q[N-1]};
        w_diff = {1'b0, w_sh} - {2'b00, r_dvs};
        w_ge   = ~w_diff[D+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= N'(i_req.dividend);
            r_dvs <= D'(i_req.divisor);
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D-1:0] : w_sh[D-1:0];
            r_q   <= {r_q[N-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: src/mfg_chk.sv
module mfg_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input mfg_pkg::t_mfg_out o_result
);

    // accepted transaction raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.grad_degenerate |->
            o_result.grad_x == '0 && o_result.grad_y == '0 && o_result.grad_z == '0
            && o_result.field_value == '0)
        else $error("degenerate gradient with nonzero fields");

    a_field_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.field_value != '0 |->
            o_result.grad_x == '0 && o_result.grad_y == '0 && o_result.grad_z == '0)
        else $error("field result carries gradient");

endmodule

bind metaball_field_gradient mfg_chk u_mfg_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_result(o_result)
);

// File: bench/tb_metaball_field_gradient.sv
module tb_metaball_field_gradient;

    localparam int N_SLOTS    = mfg_pkg::DEF_MAX_SPHERES;
    // Slowest transaction is a gradient over 16 spheres; the whole-run limit allows
    // every item that much and then several times over.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam longint unsigned CAP = 64'd65536000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    mfg_pkg::t_mfg_in  i_item = '0;
    logic              busy;
    logic              o_done;
    mfg_pkg::t_mfg_out o_result;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = mfg_pkg::CFG_SPHERE_COUNT;
    logic [7:0]        i_cfg_data = '0;

    metaball_field_gradient DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Mirror of the block: sphere table and the two registers
    // ------------------------------------------------------------------
    logic signed [15:0] ctr_x [N_SLOTS];
    logic signed [15:0] ctr_y [N_SLOTS];
    logic signed [15:0] ctr_z [N_SLOTS];
    logic [15:0]        rad   [N_SLOTS];
    logic [4:0]         active_spheres = mfg_pkg::RST_SPHERE_COUNT;
    logic [7:0]         grad_step      = mfg_pkg::RST_STEP_SIZE;

    mfg_pkg::t_mfg_out pending_results[$];
    int       err_count = 0;
    int       idle_pct  = 0;    // sender gap probability, percent
    longint   cycle_cnt = 0;

    // Field sum at an arbitrary (unwrapped) point, Q16.16, capped at 1000.0
    function automatic longint unsigned field_sum(longint px, longint py, longint pz);
        int n;
        longint dx, dy, dz;
        longint unsigned d2, r, term, sum;
        n = (active_spheres > N_SLOTS) ? N_SLOTS : int'(active_spheres);
        sum = 0;
        for (int i = 0; i < n; i++) begin
            dx = px - longint'(ctr_x[i]);
            dy = py - longint'(ctr_y[i]);
            dz = pz - longint'(ctr_z[i]);
            r  = longint'(rad[i]);
            d2 = dx*dx + dy*dy + dz*dz;
            if (d2 == 0)
                return CAP;     // point sits on a centre
            term = ((r*r) << 16) / d2;
            if (term >= CAP || sum + term >= CAP)
                sum = CAP;
            else
                sum += term;
        end
        return sum;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scale one difference to Q1.14, clamped to unit magnitude
    function automatic logic signed [15:0] unit_comp(longint g, longint unsigned len);
        longint unsigned mag, c;
        mag = (g < 0) ? -g : g;
        c = (mag << 14) / len;
        if (c > 16384)
            c = 16384;
        return (g < 0) ? -16'(c) : 16'(c);
    endfunction

    // Expected response of one transaction; loads update the table mirror
    function automatic mfg_pkg::t_mfg_out predict_result(mfg_pkg::t_mfg_in it);
        mfg_pkg::t_mfg_out r;
        longint px, py, pz, s, gx, gy, gz;
        longint unsigned sq, len;
        r = '0;
        px = longint'(it.pos_x);
        py = longint'(it.pos_y);
        pz = longint'(it.pos_z);
        s  = longint'(grad_step);
        case (it.action)
            mfg_pkg::ACT_LOAD: begin
                ctr_x[it.entry_index] = it.pos_x;
                ctr_y[it.entry_index] = it.pos_y;
                ctr_z[it.entry_index] = it.pos_z;
                rad[it.entry_index]   = it.radius;
            end
            mfg_pkg::ACT_FIELD: begin
                r.field_value = 26'(field_sum(px, py, pz));
            end
            mfg_pkg::ACT_GRAD: begin
                gx = longint'(field_sum(px+s, py, pz)) - longint'(field_sum(px-s, py, pz));
                gy = longint'(field_sum(px, py+s, pz)) - longint'(field_sum(px, py-s, pz));
                gz = longint'(field_sum(px, py, pz+s)) - longint'(field_sum(px, py, pz-s));
                sq = gx*gx + gy*gy + gz*gz;
                if (sq == 0) begin
                    r.grad_degenerate = 1'b1;
                end else begin
                    len = int_sqrt(sq);
                    r.grad_x = unit_comp(gx, len);
                    r.grad_y = unit_comp(gy, len);
                    r.grad_z = unit_comp(gz, len);
                end
            end
            default: ;  // undefined action: all zero
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: one strobe, one transaction, compared in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        mfg_pkg::t_mfg_out exp_r;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction");
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result.field_value !== exp_r.field_value) begin
                    $error("field_value exp %0d got %0d", exp_r.field_value, o_result.field_value);
                    err_count++;
                end
                if (o_result.grad_x !== exp_r.grad_x) begin
                    $error("grad_x exp %0d got %0d", exp_r.grad_x, o_result.grad_x);
                    err_count++;
                end
                if (o_result.grad_y !== exp_r.grad_y) begin
                    $error("grad_y exp %0d got %0d", exp_r.grad_y, o_result.grad_y);
                    err_count++;
                end
                if (o_result.grad_z !== exp_r.grad_z) begin
                    $error("grad_z exp %0d got %0d", exp_r.grad_z, o_result.grad_z);
                    err_count++;
                end
                if (o_result.grad_degenerate !== exp_r.grad_degenerate) begin
                    $error("grad_degenerate exp %0d got %0d",
                           exp_r.grad_degenerate, o_result.grad_degenerate);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Issue one transaction; returns at the edge that accepted it. start is
    // left high so back-to-back items need no second assignment in one step.
    task automatic send_item(mfg_pkg::t_mfg_in it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_results = {pending_results, predict_result(it)};
    endtask

    // Stop issuing and let every outstanding result come back
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mfg_pkg::CFG_SPHERE_COUNT)
            active_spheres = val[4:0];
        else
            grad_step = val;
    endtask

    function automatic mfg_pkg::t_mfg_in make_item(logic [1:0] act, logic [3:0] idx, int x,
                                                   int y, int z, int r);
        mfg_pkg::t_mfg_in it;
        it.action      = act;
        it.entry_index = idx;
        it.pos_x       = 16'(x);
        it.pos_y       = 16'(y);
        it.pos_z       = 16'(z);
        it.radius      = 16'(r);
        return it;
    endfunction

    // Mostly near the origin where the spheres live, sometimes anywhere
    function automatic int rand_coord();
        if ($urandom_range(99) < 80)
            return int'($urandom_range(4095)) - 2048;
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic mfg_pkg::t_mfg_in rand_item();
        int sel;
        logic [1:0] act;
        sel = $urandom_range(99);
        act = (sel < 25) ? mfg_pkg::ACT_LOAD :
              (sel < 57) ? mfg_pkg::ACT_FIELD :
              (sel < 95) ? mfg_pkg::ACT_GRAD : mfg_pkg::ACT_UNDEF;
        return make_item(act, 4'($urandom), rand_coord(), rand_coord(), rand_coord(),
                         ($urandom_range(99) < 70) ? int'($urandom_range(64, 1024))
                                                   : int'($urandom_range(65535)));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset state: no active spheres, so fields are zero and gradients degenerate
    task automatic test_empty_table();
        send_item(make_item(mfg_pkg::ACT_FIELD, 4'd0, 0, 0, 0, 0));
        send_item(make_item(mfg_pkg::ACT_FIELD, 4'd15, -32768, 32767, -32768, 65535));
        send_item(make_item(mfg_pkg::ACT_GRAD, 4'd0, 32767, -32768, 32767, 0));
        send_item(make_item(mfg_pkg::ACT_UNDEF, 4'd15, -1, -1, -1, 65535));
    endtask

    // Fill every slot so any count is legal afterwards
    task automatic test_load_table();
        send_item(make_item(mfg_pkg::ACT_LOAD, 4'd0, 0, 0, 0, 256));
        send_item(make_item(mfg_pkg::ACT_LOAD, 4'd15, -32768, 32767, -32768, 65535));
        for (int i = 1; i < 15; i++)
            send_item(make_item(mfg_pkg::ACT_LOAD, 4'(i), rand_coord(), rand_coord(),
                                rand_coord(), $urandom_range(64, 1024)));
    endtask

    task automatic test_field_cases();
        write_reg(mfg_pkg::CFG_SPHERE_COUNT, 8'd1);
        send_item(make_item(mfg_pkg::ACT_FIELD, 4'd0, 0, 0, 0, 0));       // on a centre
        send_item(make_item(mfg_pkg::ACT_FIELD, 4'd0, 1, 0, 0, 0));       // saturates
        send_item(make_item(mfg_pkg::ACT_FIELD, 4'd0, 32767, 32767, 32767, 0));
        send_item(make_item(mfg_pkg::ACT_GRAD, 4'd0, 256, 128, -64, 0));
        // count above the table size acts as the table size
        write_reg(mfg_pkg::CFG_SPHERE_COUNT, 8'd31);
        send_item(make_item(mfg_pkg::ACT_FIELD, 4'd0, -32768, -32768, -32768, 0));
        send_item(make_item(mfg_pkg::ACT_GRAD, 4'd0, 300, -200, 100, 0));
        write_reg(mfg_pkg::CFG_SPHERE_COUNT, 8'd16);
        send_item(make_item(mfg_pkg::ACT_FIELD, 4'd0, 32767, -32768, 32767, 0));
    endtask

    task automatic test_step_extremes();
        write_reg(mfg_pkg::CFG_SPHERE_COUNT, 8'd2);
        write_reg(mfg_pkg::CFG_STEP_SIZE, 8'd255);
        send_item(make_item(mfg_pkg::ACT_GRAD, 4'd0, 512, 0, 0, 0));
        write_reg(mfg_pkg::CFG_STEP_SIZE, 8'd1);
        send_item(make_item(mfg_pkg::ACT_GRAD, 4'd0, 0, 300, -300, 0));
        write_reg(mfg_pkg::CFG_STEP_SIZE, 8'd0);                          // zero step
        send_item(make_item(mfg_pkg::ACT_GRAD, 4'd0, 100, 100, 100, 0));
    endtask

    // One random phase at a given sender idle rate; settings change every 15 items
    task automatic test_random_traffic(int pct, int n_items);
        idle_pct = pct;
        for (int k = 0; k < n_items; k++) begin
            if (k % 15 == 0) begin
                write_reg(mfg_pkg::CFG_SPHERE_COUNT,
                          ($urandom_range(9) == 0) ? 8'd16 : 8'($urandom_range(4)));
                write_reg(mfg_pkg::CFG_STEP_SIZE, 8'($urandom_range(1, 255)));
            end
            send_item(rand_item());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_load_table();
        test_field_cases();
        test_step_extremes();
        test_random_traffic(34, 37);
        test_random_traffic(81, 37);
        test_random_traffic(0, 35);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
